[sv/pcx_rle_decoder_top_macros.svh]
// Assertion macros shared by the PCX run-length decoder checkers
`ifndef PCX_RLE_DECODER_TOP_MACROS_SVH
`define PCX_RLE_DECODER_TOP_MACROS_SVH

// Check an implication in the same cycle, clocked on clk, quiet in reset
`define PCX_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check an implication in the next cycle, clocked on clk, quiet in reset
`define PCX_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/pcx_pkg.sv]
// Shared types, constants and helpers of the PCX run-length decoder
package pcx_pkg;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 6;
  localparam int DIM_W     = 17;
  localparam int PIX_W     = 33;
  localparam int SUM_W     = PIX_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]    RUN_MARK   = 8'd192;
  localparam logic [COUNT_W-1:0]   COUNT_MASK = 6'h3F;
  localparam logic [DIM_W-1:0]     DIM_MAX    = 17'h10000;
  localparam logic [DIM_W-1:0]     DIM_MIN    = 17'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;           // latch the request, apply frame start
    logic mark_done;      // image size reached: finish, drop run state
    logic hold_header;    // keep run count, wait for run value
    logic close_run;      // zero-length run: drop run state
    logic start_literal;  // emit one literal pixel
    logic start_run;      // emit the run value count times
    logic emit;           // load one pixel into the output register
  } pcx_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic finished;
    logic at_total;
    logic awaiting;
    logic is_header;
    logic pend_zero;
    logic slot_free;
    logic last_pixel;
  } pcx_stat_t;

  // Map a raw dimension into 1..65536
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[sv/pcx_if.sv]
// Stream and configuration interfaces of the PCX run-length decoder

// Compressed byte stream
interface pcx_in_if import pcx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              frame_start;

  modport source (output valid, code_byte, frame_start, input ready);
  modport sink   (input valid, code_byte, frame_start, output ready);
endinterface

// Decoded pixel stream
interface pcx_out_if import pcx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_value;
  logic              last_in_run;
  logic              image_complete;
  logic              run_truncated;

  modport source (output valid, pixel_value, last_in_run, image_complete, run_truncated,
                  input ready);
  modport sink   (input valid, pixel_value, last_in_run, image_complete, run_truncated,
                  output ready);
endinterface

// Register write channel
interface pcx_cfg_if import pcx_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

[sv/pcx_datapath.sv]
// Datapath of the PCX run-length decoder: registers, pixel count, output stage
module pcx_datapath import pcx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pcx_cmd_t          cmd,
  output pcx_stat_t         stat,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_frame_start,
  input  logic              cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_pixel,
  output logic              out_last,
  output logic              out_complete,
  output logic              out_trunc
);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [PIX_W-1:0]   total;
  logic [2*DIM_W-1:0] product;

  logic [BYTE_W-1:0]  code_reg;
  logic               awaiting;
  logic [COUNT_W-1:0] pending;
  logic [PIX_W-1:0]   pixels_done;
  logic               finished;
  logic [COUNT_W-1:0] run_left;
  logic [BYTE_W-1:0]  run_value;
  logic               run_trunc;

  logic [PIX_W-1:0]   done_next;
  logic               hit_end;
  logic [SUM_W-1:0]   run_end;
  logic               will_trunc;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_MIN;
      image_height <= DIM_MIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image size, one register after the multiplier
  assign product = clamp_dim(image_width) * clamp_dim(image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= PIX_W'(1);
    end else begin
      total <= product[PIX_W-1:0];
    end
  end

  // Pixel count and run end checks
  assign done_next  = pixels_done + PIX_W'(1);
  assign hit_end    = done_next >= total;
  assign run_end    = {1'b0, pixels_done} + {{(SUM_W-COUNT_W){1'b0}}, pending};
  assign will_trunc = run_end > {1'b0, total};

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting    <= 1'b0;
      pending     <= '0;
      pixels_done <= '0;
      finished    <= 1'b0;
      run_left    <= '0;
    end else if (cmd.take) begin
      if (in_frame_start) begin
        awaiting    <= 1'b0;
        pending     <= '0;
        pixels_done <= '0;
        finished    <= 1'b0;
      end
    end else if (cmd.mark_done || cmd.close_run) begin
      finished <= finished | cmd.mark_done;
      awaiting <= 1'b0;
      pending  <= '0;
    end else if (cmd.hold_header) begin
      awaiting <= 1'b1;
      pending  <= code_reg[COUNT_W-1:0] & COUNT_MASK;
    end else if (cmd.start_literal) begin
      run_left <= COUNT_W'(1);
    end else if (cmd.start_run) begin
      awaiting <= 1'b0;
      pending  <= '0;
      run_left <= pending;
    end else if (cmd.emit) begin
      pixels_done <= done_next;
      run_left    <= run_left - COUNT_W'(1);
      if (hit_end) begin
        finished <= 1'b1;
      end
    end
  end

  // Request byte and run payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      code_reg <= in_byte;
    end
    if (cmd.start_literal) begin
      run_value <= code_reg;
      run_trunc <= 1'b0;
    end else if (cmd.start_run) begin
      run_value <= code_reg;
      run_trunc <= will_trunc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pixel    <= run_value;
      out_last     <= (run_left == COUNT_W'(1)) || hit_end;
      out_complete <= hit_end;
      out_trunc    <= run_trunc;
    end
  end

  // Status to the controller
  assign stat.finished   = finished;
  assign stat.at_total   = pixels_done >= total;
  assign stat.awaiting   = awaiting;
  assign stat.is_header  = code_reg >= RUN_MARK;
  assign stat.pend_zero  = pending == '0;
  assign stat.slot_free  = !out_valid || out_ready;
  assign stat.last_pixel = (run_left == COUNT_W'(1)) || hit_end;

endmodule

[sv/pcx_controller.sv]
// Controller of the PCX run-length decoder: accept, decode and emit sequencing
module pcx_controller import pcx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pcx_stat_t stat,
  output pcx_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (stat.finished) begin
          // drop bytes after the image end
        end else if (stat.at_total) begin
          cmd.mark_done = 1'b1;
        end else if (!stat.awaiting) begin
          if (stat.is_header) begin
            cmd.hold_header = 1'b1;
          end else begin
            cmd.start_literal = 1'b1;
            state_next        = S_EMIT;
          end
        end else if (stat.pend_zero) begin
          cmd.close_run = 1'b1;
        end else begin
          cmd.start_run = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.last_pixel) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/pcx_rle_decoder_top.sv]
// A literal passes the states idle, decode and emit, a run header idle and decode, and
// a run value idle, decode and then emit once for each pixel of its count;
// the one shared pixel sequencer emits one pixel per cycle while the output drains.
// A run value stalls new requests until its last pixel is in the output register.
// Synchronous active-high reset: image size 1 x 1, count and run state cleared.
// Image size is registered after one multiplier, so it settles after the size registers.
module pcx_rle_decoder_top import pcx_pkg::*; (
  input logic      clk,
  input logic      rst,
  pcx_in_if.sink   codes,
  pcx_out_if.source pixels,
  pcx_cfg_if.sink  cfg
);

  pcx_cmd_t  cmd;
  pcx_stat_t stat;

  // Registers are always writable
  assign cfg.ready = 1'b1;

  pcx_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (codes.valid),
    .in_ready (codes.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcx_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte        (codes.code_byte),
    .in_frame_start (codes.frame_start),
    .cfg_write      (cfg.valid && cfg.ready),
    .cfg_index      (cfg.reg_index),
    .cfg_data       (cfg.data),
    .out_ready      (pixels.ready),
    .out_valid      (pixels.valid),
    .out_pixel      (pixels.pixel_value),
    .out_last       (pixels.last_in_run),
    .out_complete   (pixels.image_complete),
    .out_trunc      (pixels.run_truncated)
  );

endmodule

[sv/pcx_checker.sv]
// Port-level checks of the PCX run-length decoder, bound to the top level
`include "pcx_rle_decoder_top_macros.svh"

module pcx_checker import pcx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] pixel_value,
  input logic              last_in_run,
  input logic              image_complete,
  input logic              run_truncated
);

  // A stalled pixel holds
  `PCX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_value), "stalled pixel changed")

  // One request at a time: decode follows every accept
  `PCX_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request taken during decode")

  // The image end always closes the request's pixels
  `PCX_ASSERT_NOW(a_end_last, out_valid && image_complete, last_in_run, "image end not last in run")

  // A cut run ends exactly at the image end
  `PCX_ASSERT_NOW(a_trunc_end, out_valid && run_truncated && last_in_run, image_complete, "truncated run ended early")

endmodule

bind pcx_rle_decoder_top pcx_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (codes.valid),
  .in_ready       (codes.ready),
  .out_valid      (pixels.valid),
  .out_ready      (pixels.ready),
  .pixel_value    (pixels.pixel_value),
  .last_in_run    (pixels.last_in_run),
  .image_complete (pixels.image_complete),
  .run_truncated  (pixels.run_truncated)
);

[test/tb_top.sv]
// Self-checking testbench of the PCX run-length decoder: directed and random frames
module tb_top;
  import pcx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // index with no register behind it
  localparam int QUIET_CYCLES = 8;     // pipeline drain before a register write
  localparam int SETTLE_CYCLES = 2;    // image size registers after a write, behind the size registers
  localparam int DRAIN_CYCLES = 20;    // tail after the last expected pixel
  localparam int STALL_LIMIT = 3000;   // cycles with no request moving on any channel
  localparam int RANDOM_ITEMS = 24;    // per idling mode

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              complete;
    logic              trunc;
  } pixel_t;

  logic clk;
  logic rst;

  pcx_in_if  codes_if ();
  pcx_out_if pixels_if ();
  pcx_cfg_if cfg_if ();

  pcx_rle_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .codes  (codes_if),
    .pixels (pixels_if),
    .cfg    (cfg_if)
  );

  // Predicted decoder state
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic               want_value;
  logic [COUNT_W-1:0] run_count;
  longint             pixel_count;
  logic               img_finished;

  pixel_t expected_pixels[$];
  int     errors = 0;
  int     send_idle;
  int     recv_idle;
  int     stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective dimension: zero reads as one, oversize saturates
  function automatic longint eff_dim(input logic [DIM_W-1:0] v);
    longint r;
    r = longint'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > 65536) begin
      r = 65536;
    end
    return r;
  endfunction

  function automatic void push_pixel(input logic [BYTE_W-1:0] value, input logic last,
                                     input logic complete, input logic trunc);
    pixel_t p;
    p.value = value;
    p.last = last;
    p.complete = complete;
    p.trunc = trunc;
    expected_pixels.push_back(p);
  endfunction

  // Decode one accepted byte into the pixels it produces
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic fs);
    longint total;
    longint remaining;
    longint count;
    logic   trunc;
    longint k;
    if (fs) begin
      want_value = 1'b0;
      run_count = '0;
      pixel_count = 0;
      img_finished = 1'b0;
    end
    if (img_finished) return;
    total = eff_dim(width_reg) * eff_dim(height_reg);
    // Image already full, e.g. after the size shrank: finish and drop the byte
    if (pixel_count >= total) begin
      img_finished = 1'b1;
      want_value = 1'b0;
      run_count = '0;
      return;
    end
    remaining = total - pixel_count;
    if (!want_value) begin
      if (b < RUN_MARK) begin
        pixel_count++;
        if (pixel_count >= total) img_finished = 1'b1;
        push_pixel(b, 1'b1, img_finished, 1'b0);
        return;
      end
      run_count = b[COUNT_W-1:0] & COUNT_MASK;
      want_value = 1'b1;
      return;
    end
    // Run value: repeat it, cut the run at the image end
    want_value = 1'b0;
    count = longint'(run_count);
    run_count = '0;
    trunc = 1'b0;
    if (count > remaining) begin
      count = remaining;
      trunc = 1'b1;
    end
    for (k = 0; k < count; k++) begin
      pixel_count++;
      if (pixel_count >= total) img_finished = 1'b1;
      push_pixel(b, k == count - 1, (k == count - 1) && img_finished, trunc);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Track register writes, predict on each byte request, check each pixel
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      width_reg = DIM_MIN;
      height_reg = DIM_MIN;
      want_value = 1'b0;
      run_count = '0;
      pixel_count = 0;
      img_finished = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.reg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_if.data;
        end else if (cfg_if.reg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_if.data;
        end
      end
      if (codes_if.valid && codes_if.ready) begin
        decode_byte(codes_if.code_byte, codes_if.frame_start);
      end
      if (pixels_if.valid && pixels_if.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel value", int'(pixels_if.pixel_value), -1);
        end else begin
          e = expected_pixels.pop_front();
          if (pixels_if.pixel_value !== e.value)
            report_mismatch("pixel_value", int'(pixels_if.pixel_value), int'(e.value));
          if (pixels_if.last_in_run !== e.last)
            report_mismatch("last_in_run", int'(pixels_if.last_in_run), int'(e.last));
          if (pixels_if.image_complete !== e.complete)
            report_mismatch("image_complete", int'(pixels_if.image_complete),
                            int'(e.complete));
          if (pixels_if.run_truncated !== e.trunc)
            report_mismatch("run_truncated", int'(pixels_if.run_truncated), int'(e.trunc));
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if (rst || (codes_if.valid && codes_if.ready) || (pixels_if.valid && pixels_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Pixel receiver: stall at random
  always @(negedge clk) begin
    pixels_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Send one byte request; call and return at a falling edge
  task automatic send_code(input logic [BYTE_W-1:0] b, input logic fs);
    while ($urandom_range(99) < send_idle) begin
      codes_if.valid <= 1'b0;
      @(negedge clk);
    end
    codes_if.valid <= 1'b1;
    codes_if.code_byte <= b;
    codes_if.frame_start <= fs;
    @(posedge clk);
    while (!codes_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register once the decoder has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    codes_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Literal extremes inside a 4 x 4 image
  task automatic test_literals();
    set_size(17'd4, 17'd4);
    send_code(8'd0, 1'b1);
    send_code(8'd191, 1'b0);
    send_code(8'd85, 1'b0);
    send_code(8'd170, 1'b0);
  endtask

  // Zero-length run, longest run, one-pixel run
  task automatic test_runs();
    set_size(17'd16, 17'd8);
    send_code(8'd192, 1'b1);
    send_code(8'd77, 1'b0);
    send_code(8'd255, 1'b0);
    send_code(8'd255, 1'b0);
    send_code(8'd193, 1'b0);
    send_code(8'd0, 1'b0);
  endtask

  // Run cut at the image end, then bytes after completion, then a new frame
  task automatic test_completion();
    set_size(17'd2, 17'd2);
    send_code(8'd9, 1'b1);
    send_code(8'd197, 1'b0);
    send_code(8'd170, 1'b0);
    send_code(8'd10, 1'b0);
    send_code(8'd200, 1'b0);
    send_code(8'd33, 1'b1);
  endtask

  // Out-of-range sizes, the largest image, and a write to a spare index
  task automatic test_dimensions();
    set_size(17'd0, 17'h1FFFF);
    send_code(8'd1, 1'b1);
    set_size(DIM_MAX, DIM_MAX);
    send_code(8'd254, 1'b1);
    send_code(8'd250, 1'b0);
    write_reg(REG_SPARE, 17'h1FFFF);
  endtask

  // Shrink the image under a frame in progress
  task automatic test_shrink();
    set_size(17'd8, 17'd8);
    send_code(8'd12, 1'b1);
    send_code(8'd13, 1'b0);
    set_size(17'd1, 17'd1);
    send_code(8'd14, 1'b0);
    send_code(8'd15, 1'b1);
  endtask

  // Well-formed frames with random content, some noise and restarts
  task automatic test_random_frames();
    int mode;
    int items;
    int n;
    int kind;
    logic fs;
    for (mode = 0; mode < 3; mode++) begin
      if (mode == 0) begin
        send_idle = 29;
        recv_idle = 53;
      end else if (mode == 1) begin
        send_idle = 53;
        recv_idle = 29;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      items = 0;
      while (items < RANDOM_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          set_size(DIM_W'($urandom_range(17'h1FFFF)), DIM_W'($urandom_range(17'h1FFFF)));
        end else begin
          set_size(DIM_W'($urandom_range(6)), DIM_W'($urandom_range(6)));
        end
        fs = 1'b1;
        n = 0;
        while (!img_finished && n < 14) begin
          kind = $urandom_range(99);
          if (kind < 55) begin
            send_code(BYTE_W'($urandom_range(191)), fs);
            n++;
          end else if (kind < 90) begin
            send_code(RUN_MARK | BYTE_W'($urandom_range(63)), fs);
            send_code(BYTE_W'($urandom_range(255)), 1'b0);
            n += 2;
          end else begin
            send_code(BYTE_W'($urandom_range(255)), fs | 1'($urandom_range(1)));
            n++;
          end
          fs = 1'b0;
        end
        // Trailing bytes after the image end are dropped
        repeat ($urandom_range(2)) begin
          send_code(BYTE_W'($urandom_range(255)), 1'b0);
          n++;
        end
        items += n;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    send_idle = 0;
    recv_idle = 0;
    codes_if.valid <= 1'b0;
    codes_if.code_byte <= '0;
    codes_if.frame_start <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_literals();
    test_runs();
    test_completion();
    test_dimensions();
    test_shrink();
    test_random_frames();

    // Drain the output and give a stray pixel time to show
    codes_if.valid <= 1'b0;
    recv_idle = 0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/pcx_pkg.sv
sv/pcx_if.sv
sv/pcx_datapath.sv
sv/pcx_controller.sv
sv/pcx_rle_decoder_top.sv
sv/pcx_checker.sv
test/tb_top.sv
